// ===== src/mosp_pkg.sv =====
// shared types, constants and helper functions for the mosaic slot pixel placer
`default_nettype none
package mosp_pkg;

  localparam int DIM_W = 13;
  localparam int POS_W = 12;
  localparam int ADDR_W = 25;
  localparam int SUM_W = 30;
  localparam int AREA_W = 2 * DIM_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [7:0] CLEAR_VALUE = 8'd128;
  localparam logic [16:0] DIV3_MAGIC = 17'd43691;

  typedef enum logic [1:0] {
    LAYOUT_3P4  = 2'd0,
    LAYOUT_1P7  = 2'd1,
    LAYOUT_1P5  = 2'd2,
    LAYOUT_1P1C = 2'd3
  } layout_t;

  typedef enum logic [1:0] {
    REG_LAYOUT       = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_SLOT_COUNT   = 2'd3
  } reg_index_t;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  typedef enum logic [2:0] {
    SZ_HALF      = 3'd0,
    SZ_QUARTER   = 3'd1,
    SZ_THREE_QTR = 3'd2,
    SZ_TWO_THIRD = 3'd3,
    SZ_THIRD     = 3'd4
  } size_class_t;

  typedef struct packed {
    logic             operation;
    logic [2:0]       slot;
    logic [1:0]       plane;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic [7:0]       pixel_value;
    logic [DIM_W-1:0] picture_width;
    logic [DIM_W-1:0] picture_height;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    logic [7:0]        pixel_out;
    logic              write_enable;
    logic              slot_rejected;
    logic              needs_resize;
    logic [DIM_W-1:0]  slot_width;
    logic [DIM_W-1:0]  slot_height;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  w_half;
    logic [DIM_W-1:0]  w_qtr;
    logic [DIM_W-1:0]  w_3q;
    logic [DIM_W-1:0]  w_2t;
    logic [DIM_W-1:0]  w_3rd;
    logic [DIM_W-1:0]  h_half;
    logic [DIM_W-1:0]  h_qtr;
    logic [DIM_W-1:0]  h_3q;
    logic [DIM_W-1:0]  h_2t;
    logic [DIM_W-1:0]  h_3rd;
    logic [AREA_W-1:0] wh;
  } dims_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  gi;
    logic [1:0]  gj;
    size_class_t size;
  } geom_t;

  typedef struct packed {
    logic             rejected;
    logic [1:0]       plane;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic [7:0]       pixel_out;
    logic             write_enable;
    logic             needs_resize;
    logic [DIM_W-1:0] slot_width;
    logic [DIM_W-1:0] slot_height;
    logic [1:0]       gi;
    logic [1:0]       gj;
  } task_t;

  // exact x/3 for x below 2^14
  function automatic logic [DIM_W-1:0] div3(input logic [DIM_W:0] x);
    logic [30:0] p;
    p = 31'(x) * 31'(DIV3_MAGIC);
    return p[DIM_W+16:17];
  endfunction

  function automatic geom_t slot_geom(input layout_t lay, input logic [2:0] s);
    geom_t g;
    g = '0;
    g.ok = 1'b1;
    unique case (lay)
      LAYOUT_3P4: begin
        g.size = (s < 3'd3) ? SZ_HALF : SZ_QUARTER;
        unique case (s)
          3'd0: begin g.gi = 2'd0; g.gj = 2'd0; end
          3'd1: begin g.gi = 2'd0; g.gj = 2'd1; end
          3'd2: begin g.gi = 2'd1; g.gj = 2'd0; end
          3'd3: begin g.gi = 2'd2; g.gj = 2'd2; end
          3'd4: begin g.gi = 2'd2; g.gj = 2'd3; end
          3'd5: begin g.gi = 2'd3; g.gj = 2'd2; end
          3'd6: begin g.gi = 2'd3; g.gj = 2'd3; end
          default: g.ok = 1'b0;
        endcase
      end
      LAYOUT_1P7: begin
        g.size = (s == 3'd0) ? SZ_THREE_QTR : SZ_QUARTER;
        unique case (s)
          3'd0: begin g.gi = 2'd0; g.gj = 2'd0; end
          3'd1: begin g.gi = 2'd0; g.gj = 2'd3; end
          3'd2: begin g.gi = 2'd1; g.gj = 2'd3; end
          3'd3: begin g.gi = 2'd2; g.gj = 2'd3; end
          3'd4: begin g.gi = 2'd3; g.gj = 2'd0; end
          3'd5: begin g.gi = 2'd3; g.gj = 2'd1; end
          3'd6: begin g.gi = 2'd3; g.gj = 2'd2; end
          default: begin g.gi = 2'd3; g.gj = 2'd3; end
        endcase
      end
      LAYOUT_1P5: begin
        g.size = (s == 3'd0) ? SZ_TWO_THIRD : SZ_THIRD;
        unique case (s)
          3'd0: begin g.gi = 2'd0; g.gj = 2'd0; end
          3'd1: begin g.gi = 2'd0; g.gj = 2'd2; end
          3'd2: begin g.gi = 2'd1; g.gj = 2'd2; end
          3'd3: begin g.gi = 2'd2; g.gj = 2'd0; end
          3'd4: begin g.gi = 2'd2; g.gj = 2'd1; end
          3'd5: begin g.gi = 2'd2; g.gj = 2'd2; end
          default: g.ok = 1'b0;
        endcase
      end
      default: begin
        g.size = SZ_HALF;
        g.gi = 2'd0;
        g.gj = {1'b0, s[0]};
        g.ok = (s < 3'd2);
      end
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== src/mosp_front.sv =====
// front part: takes one transaction, resolves slot geometry, checks and classifies it
`default_nettype none
module mosp_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire mosp_pkg::request_t  request,
  input  wire mosp_pkg::layout_t   layout,
  input  wire logic [3:0]          slot_count,
  input  wire mosp_pkg::dims_t     dims,
  input  wire logic                full,
  output logic                     push,
  output mosp_pkg::task_t          entry
);

  mosp_pkg::request_t held;
  logic               held_valid;
  mosp_pkg::geom_t    g;
  logic [mosp_pkg::DIM_W-1:0] sw;
  logic [mosp_pkg::DIM_W-1:0] sh;
  logic in_slot;
  logic same;
  logic rejected;

  assign busy = held_valid && full;
  assign push = held_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (start && !busy) begin
      held_valid <= 1'b1;
    end else if (push) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      held <= request;
    end
  end

  always_comb begin
    g = mosp_pkg::slot_geom(layout, held.slot);
    rejected = !g.ok || ({1'b0, held.slot} >= slot_count);
    unique case (g.size)
      mosp_pkg::SZ_HALF:      begin sw = dims.w_half; sh = dims.h_half; end
      mosp_pkg::SZ_QUARTER:   begin sw = dims.w_qtr;  sh = dims.h_qtr;  end
      mosp_pkg::SZ_THREE_QTR: begin sw = dims.w_3q;   sh = dims.h_3q;   end
      mosp_pkg::SZ_TWO_THIRD: begin sw = dims.w_2t;   sh = dims.h_2t;   end
      mosp_pkg::SZ_THIRD:     begin sw = dims.w_3rd;  sh = dims.h_3rd;  end
      default:                begin sw = dims.w_half; sh = dims.h_half; end
    endcase
    if (held.plane == mosp_pkg::PLANE_Y) begin
      in_slot = ({1'b0, held.row} < sh) && ({1'b0, held.column} < sw);
    end else if (held.plane == mosp_pkg::PLANE_U || held.plane == mosp_pkg::PLANE_V) begin
      in_slot = ({1'b0, held.row} < (sh >> 1)) && ({1'b0, held.column} < (sw >> 1));
    end else begin
      in_slot = 1'b0;
    end
    same = (held.picture_width == sw) && (held.picture_height == sh);

    entry = '0;
    if (rejected) begin
      entry.rejected = 1'b1;
    end else begin
      entry.plane       = held.plane;
      entry.row         = held.row;
      entry.column      = held.column;
      entry.slot_width  = sw;
      entry.slot_height = sh;
      entry.gi          = g.gi;
      entry.gj          = g.gj;
      if (held.operation == mosp_pkg::OP_CLEAR) begin
        entry.pixel_out    = mosp_pkg::CLEAR_VALUE;
        entry.write_enable = in_slot;
      end else begin
        entry.pixel_out    = held.pixel_value;
        entry.write_enable = in_slot && same;
        entry.needs_resize = !same && (held.picture_width != '0)
                             && (held.picture_height != '0);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/mosp_queue.sv =====
// short queue of classified transactions between front and back
`default_nettype none
module mosp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire mosp_pkg::task_t  din,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output mosp_pkg::task_t       head
);

  mosp_pkg::task_t               slots [mosp_pkg::QUEUE_DEPTH];
  logic [mosp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [mosp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [mosp_pkg::QPTR_W:0]     count;
  logic do_push;
  logic do_pop;

  assign full    = count == (mosp_pkg::QPTR_W + 1)'(mosp_pkg::QUEUE_DEPTH);
  assign valid   = count != '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== src/mosp_back.sv =====
// back part: three-stage address pipeline and result register
`default_nettype none
module mosp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire mosp_pkg::task_t  entry,
  output logic                  pop,
  input  wire logic             centered,
  input  wire mosp_pkg::dims_t  dims,
  output logic                  done,
  output mosp_pkg::result_t     result
);

  localparam int SW = mosp_pkg::SUM_W;

  logic                          s1_valid;
  mosp_pkg::task_t               s1;
  logic [mosp_pkg::AREA_W-1:0]   s1_wsh;
  logic [mosp_pkg::ADDR_W-1:0]   s1_rowterm;
  logic [mosp_pkg::DIM_W+1:0]    s1_swgj;
  logic [mosp_pkg::DIM_W-1:0]    row_scale;

  logic                          s2_valid;
  mosp_pkg::task_t               s2;
  logic [SW-1:0]                 s2_offset;
  logic [SW-1:0]                 s2_rel;

  logic [SW-1:0] wsh_gi;
  logic [SW-1:0] yoff;
  logic [SW-1:0] coff;
  logic [SW-1:0] offset_next;
  logic [SW-1:0] rel_next;
  logic [SW-1:0] addr;
  mosp_pkg::result_t result_next;

  assign pop = in_valid;

  // stage 1: products
  always_comb begin
    row_scale = (entry.plane == mosp_pkg::PLANE_Y) ? dims.w : dims.w_half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1         <= entry;
      s1_wsh     <= mosp_pkg::AREA_W'(dims.w) * mosp_pkg::AREA_W'(entry.slot_height);
      s1_rowterm <= mosp_pkg::ADDR_W'(entry.row) * mosp_pkg::ADDR_W'(row_scale);
      s1_swgj    <= (mosp_pkg::DIM_W + 2)'(entry.slot_width)
                    * (mosp_pkg::DIM_W + 2)'(entry.gj);
    end
  end

  // stage 2: slot offset and plane base
  always_comb begin
    wsh_gi = SW'(s1_wsh) * SW'(s1.gi);
    yoff = wsh_gi + SW'(s1_swgj) + (centered ? SW'(s1_wsh >> 1) : '0);
    coff = (wsh_gi >> 2) + SW'(s1_swgj >> 1) + (centered ? SW'(s1_wsh >> 3) : '0);
    rel_next = SW'(s1_rowterm) + SW'(s1.column);
    if (s1.plane == mosp_pkg::PLANE_Y) begin
      offset_next = yoff;
    end else if (s1.plane == mosp_pkg::PLANE_U) begin
      offset_next = SW'(dims.wh) + coff;
    end else if (s1.plane == mosp_pkg::PLANE_V) begin
      offset_next = SW'(dims.wh) + SW'(dims.wh >> 2) + coff;
    end else begin
      offset_next = '0;
      rel_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2        <= s1;
      s2_offset <= offset_next;
      s2_rel    <= rel_next;
    end
  end

  // stage 3: final address and result register
  assign addr = s2_offset + s2_rel;

  always_comb begin
    result_next = '0;
    if (s2.rejected) begin
      result_next.slot_rejected = 1'b1;
    end else begin
      result_next.frame_address = addr[mosp_pkg::ADDR_W-1:0];
      result_next.pixel_out     = s2.pixel_out;
      result_next.write_enable  = s2.write_enable;
      result_next.needs_resize  = s2.needs_resize;
      result_next.slot_width    = s2.slot_width;
      result_next.slot_height   = s2.slot_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/mosaic_slot_pixel_placer_unit.sv =====
// top level of the mosaic slot pixel placer: config registers, front, queue, back
// path of a transaction: front register, queue, stage 1, stage 2, result register
// throughput: one per cycle while not busy, set by the single-issue front register
// and the three-stage address pipeline behind the queue; results cannot be stalled
// reset (rst, synchronous): layout 0, 640x480 frame, 7 slots; pipeline emptied
`default_nettype none
module mosaic_slot_pixel_placer_unit #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire mosp_pkg::request_t  request,
  output logic                     done,
  output mosp_pkg::result_t        result,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [mosp_pkg::DIM_W-1:0] cfg_data
);

  localparam int DW1 = mosp_pkg::DIM_W + 1;
  localparam logic [DW1-1:0] MAX_DIM_V = DW1'(MAX_DIMENSION);

  mosp_pkg::layout_t          layout;
  logic [mosp_pkg::DIM_W-1:0] frame_width;
  logic [mosp_pkg::DIM_W-1:0] frame_height;
  logic [3:0]                 slot_count;
  mosp_pkg::dims_t            dims;
  mosp_pkg::dims_t            dims_next;
  logic [mosp_pkg::DIM_W-1:0] w_clamp;
  logic [mosp_pkg::DIM_W-1:0] h_clamp;
  logic [mosp_pkg::DIM_W+1:0] w_x3;
  logic [mosp_pkg::DIM_W+1:0] h_x3;

  logic            push;
  logic            full;
  mosp_pkg::task_t entry;
  logic            q_valid;
  logic            q_pop;
  mosp_pkg::task_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout       <= mosp_pkg::LAYOUT_3P4;
      frame_width  <= mosp_pkg::DIM_W'(640);
      frame_height <= mosp_pkg::DIM_W'(480);
      slot_count   <= 4'd7;
    end else if (cfg_write) begin
      unique case (mosp_pkg::reg_index_t'(cfg_index))
        mosp_pkg::REG_LAYOUT:       layout       <= mosp_pkg::layout_t'(cfg_data[1:0]);
        mosp_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        mosp_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        mosp_pkg::REG_SLOT_COUNT:   slot_count   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // slot sizes follow the frame registers in the next cycle
  always_comb begin
    w_clamp = ({1'b0, frame_width} > MAX_DIM_V) ? MAX_DIM_V[mosp_pkg::DIM_W-1:0] : frame_width;
    h_clamp = ({1'b0, frame_height} > MAX_DIM_V) ? MAX_DIM_V[mosp_pkg::DIM_W-1:0] : frame_height;
    w_x3 = {2'b00, w_clamp} + {1'b0, w_clamp, 1'b0};
    h_x3 = {2'b00, h_clamp} + {1'b0, h_clamp, 1'b0};
    dims_next.w      = w_clamp;
    dims_next.w_half = w_clamp >> 1;
    dims_next.w_qtr  = w_clamp >> 2;
    dims_next.w_3q   = w_x3[mosp_pkg::DIM_W+1:2];
    dims_next.w_2t   = mosp_pkg::div3({w_clamp, 1'b0});
    dims_next.w_3rd  = mosp_pkg::div3({1'b0, w_clamp});
    dims_next.h_half = h_clamp >> 1;
    dims_next.h_qtr  = h_clamp >> 2;
    dims_next.h_3q   = h_x3[mosp_pkg::DIM_W+1:2];
    dims_next.h_2t   = mosp_pkg::div3({h_clamp, 1'b0});
    dims_next.h_3rd  = mosp_pkg::div3({1'b0, h_clamp});
    dims_next.wh     = mosp_pkg::AREA_W'(w_clamp) * mosp_pkg::AREA_W'(h_clamp);
  end

  always_ff @(posedge clk) begin
    dims <= dims_next;
  end

  mosp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .layout     (layout),
    .slot_count (slot_count),
    .dims       (dims),
    .full       (full),
    .push       (push),
    .entry      (entry)
  );

  mosp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .full  (full),
    .pop   (q_pop),
    .valid (q_valid),
    .head  (q_head)
  );

  mosp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .entry    (q_head),
    .pop      (q_pop),
    .centered (layout == mosp_pkg::LAYOUT_1P1C),
    .dims     (dims),
    .done     (done),
    .result   (result)
  );

  // the back part never stalls, so the queue never fills
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("queue filled up");

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("transaction lost");

  a_latency_bwd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without transaction");

  a_rejected_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && result.slot_rejected) |->
      (!result.write_enable && !result.needs_resize && result.frame_address == '0))
    else $error("rejected slot produced a write");

endmodule
`default_nettype wire
